@@ rtl/core/sclp_pkg.sv @@
// Package for the serial command line parser: command codes, characters
// and the word identifiers for token matching. No dependencies.
`default_nettype none
package sclp_pkg;
    localparam logic [3:0] CMD_UNKNOWN = 4'd0;
    localparam logic [3:0] CMD_HELP    = 4'd1;
    localparam logic [3:0] CMD_STATUS  = 4'd2;
    localparam logic [3:0] CMD_BIN_ON  = 4'd3;
    localparam logic [3:0] CMD_BIN_OFF = 4'd4;
    localparam logic [3:0] CMD_MOT_POS = 4'd5;
    localparam logic [3:0] CMD_MOT_SPD = 4'd6;
    localparam logic [3:0] CMD_DIR_FWD = 4'd7;
    localparam logic [3:0] CMD_DIR_REV = 4'd8;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Word identifiers for token matching.
    localparam logic [3:0] W_NONE   = 4'd0;
    localparam logic [3:0] W_HELP   = 4'd1;
    localparam logic [3:0] W_STATUS = 4'd2;
    localparam logic [3:0] W_BIN    = 4'd3;
    localparam logic [3:0] W_ON     = 4'd4;
    localparam logic [3:0] W_OFF    = 4'd5;
    localparam logic [3:0] W_MOT    = 4'd6;
    localparam logic [3:0] W_POS    = 4'd7;
    localparam logic [3:0] W_SPD    = 4'd8;
    localparam logic [3:0] W_DIR    = 4'd9;
    localparam logic [3:0] W_FWD    = 4'd10;
    localparam logic [3:0] W_REV    = 4'd11;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        upcase = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
    endfunction

    // Character k (0..5) of word w, 0 past the end.
    function automatic logic [7:0] word_char(input logic [3:0] w, input logic [2:0] k);
        logic [47:0] s;
        s = 48'h0;
        unique case (w)
            W_HELP:   s = {"HELP", 16'h0};
            W_STATUS: s = "STATUS";
            W_BIN:    s = {"BIN", 24'h0};
            W_ON:     s = {"ON", 32'h0};
            W_OFF:    s = {"OFF", 24'h0};
            W_MOT:    s = {"MOT", 24'h0};
            W_POS:    s = {"POS", 24'h0};
            W_SPD:    s = {"SPD", 24'h0};
            W_DIR:    s = {"DIR", 24'h0};
            W_FWD:    s = {"FWD", 24'h0};
            W_REV:    s = {"REV", 24'h0};
            default:  s = 48'h0;
        endcase
        word_char = (k > 3'd5) ? 8'h0 : s[8'd47 - {k, 3'b000} -: 8];
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/sclp_scan.sv @@
// Token scanner for the serial command line parser: walks the line store one
// byte at a time, matches the first tokens to words and accumulates the number.
// Depends on sclp_pkg.
`default_nettype none
module sclp_scan #(
    parameter int LINE_BYTES = 64,
    parameter int MAX_TOKENS = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [$clog2(LINE_BYTES):0]   i_len,
    input  wire logic [7:0]                    i_rd_data,
    output logic      [$clog2(LINE_BYTES)-1:0] o_rd_addr,
    output logic                               o_done,
    output logic      [3:0]                    o_code,
    output logic      [31:0]                   o_value
);
    localparam int AW = $clog2(LINE_BYTES);
    localparam int TW = $clog2(MAX_TOKENS + 1);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    // Per-token match flags: bit order follows the word ids.
    logic [1:0]    r_state, n_state;
    logic [AW:0]   r_pos, n_pos;
    logic [TW-1:0] r_ntok, n_ntok;
    logic          r_in_tok, n_in_tok;
    logic [2:0]    r_k, n_k;
    logic          r_long, n_long;
    logic [11:0]   r_cand, n_cand;
    logic [3:0]    r_w0, n_w0, r_w1, n_w1, r_w2, n_w2;
    // Number reader phase: 0 before the sign, 1 reading digits, 2 stopped.
    logic [1:0]    r_nph, n_nph;
    logic          r_neg, n_neg;
    logic [31:0]   r_mag, n_mag;
    logic          r_done;
    logic [3:0]    r_code, n_code;
    logic [31:0]   r_value, n_value;

    logic [7:0] ch, uc;
    logic       at_end, is_sep;
    logic [3:0] word_id;
    logic [35:0] mag10;

    assign ch = i_rd_data;
    assign uc = sclp_pkg::upcase(ch);
    assign o_rd_addr = r_pos[AW-1:0];
    assign mag10 = {r_mag, 3'b000} + {2'b00, r_mag, 1'b0} + {28'h0, ch - 8'h30};

    always_comb begin
        word_id = sclp_pkg::W_NONE;
        for (int w = 11; w >= 1; w--) begin
            if (r_cand[w] && !r_long && sclp_pkg::word_char(4'(w), r_k) == 8'h0)
                word_id = 4'(w);
        end
    end

    always_comb begin
        n_state = r_state; n_pos = r_pos; n_ntok = r_ntok; n_in_tok = r_in_tok;
        n_k = r_k; n_long = r_long; n_cand = r_cand;
        n_w0 = r_w0; n_w1 = r_w1; n_w2 = r_w2;
        n_nph = r_nph; n_neg = r_neg; n_mag = r_mag;
        n_code = r_code; n_value = r_value;
        at_end = (r_pos >= i_len) || (ch == 8'h0);
        is_sep = (ch == sclp_pkg::CH_SP) || (ch == sclp_pkg::CH_TAB);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_pos = '0; n_ntok = '0; n_in_tok = 1'b0;
                    n_w0 = sclp_pkg::W_NONE; n_w1 = sclp_pkg::W_NONE;
                    n_w2 = sclp_pkg::W_NONE;
                    n_nph = 2'd0; n_neg = 1'b0; n_mag = '0;
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_SCAN;
            S_SCAN: begin
                if (r_pos >= i_len) at_end = 1'b1;
                if (at_end || (r_in_tok && is_sep)) begin
                    if (r_in_tok) begin
                        if (r_ntok == TW'(1)) n_w0 = word_id;
                        if (r_ntok == TW'(2)) n_w1 = word_id;
                        if (r_ntok == TW'(3)) n_w2 = word_id;
                    end
                    n_in_tok = 1'b0;
                end else if (!r_in_tok && !is_sep && r_ntok < TW'(MAX_TOKENS)) begin
                    n_in_tok = 1'b1;
                    n_ntok = r_ntok + TW'(1);
                    n_k = 3'd0; n_long = 1'b0;
                    n_cand = '1;
                end
                if (!at_end && (n_in_tok && (r_in_tok || !is_sep))) begin
                    for (int w = 1; w <= 11; w++)
                        if (sclp_pkg::word_char(4'(w), n_k) != uc) n_cand[w] = 1'b0;
                    if (n_k == 3'd7) n_long = 1'b1;
                    else n_k = n_k + 3'd1;
                    // Third token feeds the number reader.
                    if (n_ntok == TW'(3)) begin
                        if (n_nph == 2'd0 && (ch == sclp_pkg::CH_VT || ch == sclp_pkg::CH_FF)) begin
                        end else if (n_nph == 2'd0 && (ch == sclp_pkg::CH_PLUS ||
                                                       ch == sclp_pkg::CH_MINUS)) begin
                            n_neg = (ch == sclp_pkg::CH_MINUS);
                            n_nph = 2'd1;
                        end else if (n_nph != 2'd2 && ch >= 8'h30 && ch <= 8'h39) begin
                            n_nph = 2'd1;
                            n_mag = (mag10 > {4'h0, sclp_pkg::MAG_LIMIT})
                                  ? sclp_pkg::MAG_LIMIT : mag10[31:0];
                        end else begin
                            n_nph = 2'd2;
                        end
                    end
                end
                if (at_end) begin
                    n_state = S_IDLE;
                    n_code = sclp_pkg::CMD_UNKNOWN;
                    n_value = '0;
                    if (n_w0 == sclp_pkg::W_HELP) n_code = sclp_pkg::CMD_HELP;
                    else if (n_w0 == sclp_pkg::W_STATUS) n_code = sclp_pkg::CMD_STATUS;
                    else if (n_w0 == sclp_pkg::W_BIN) begin
                        if (n_w1 == sclp_pkg::W_ON) n_code = sclp_pkg::CMD_BIN_ON;
                        else if (n_w1 == sclp_pkg::W_OFF) n_code = sclp_pkg::CMD_BIN_OFF;
                    end else if (n_w0 == sclp_pkg::W_MOT && n_ntok >= TW'(3)) begin
                        if (n_w1 == sclp_pkg::W_POS || n_w1 == sclp_pkg::W_SPD) begin
                            n_code = (n_w1 == sclp_pkg::W_POS) ? sclp_pkg::CMD_MOT_POS
                                                               : sclp_pkg::CMD_MOT_SPD;
                            if (n_neg) n_value = 32'h0 - n_mag;
                            else n_value = (n_mag == sclp_pkg::MAG_LIMIT) ? 32'h7FFF_FFFF
                                                                          : n_mag;
                        end else if (n_w1 == sclp_pkg::W_DIR) begin
                            if (n_w2 == sclp_pkg::W_FWD) n_code = sclp_pkg::CMD_DIR_FWD;
                            else if (n_w2 == sclp_pkg::W_REV) n_code = sclp_pkg::CMD_DIR_REV;
                        end
                    end
                end else begin
                    n_pos = r_pos + (AW+1)'(1);
                    n_state = S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_SCAN) && (n_state == S_IDLE);
        end
        r_pos <= n_pos; r_ntok <= n_ntok; r_in_tok <= n_in_tok; r_k <= n_k;
        r_long <= n_long; r_cand <= n_cand; r_w0 <= n_w0; r_w1 <= n_w1; r_w2 <= n_w2;
        r_nph <= n_nph; r_neg <= n_neg; r_mag <= n_mag;
        r_code <= n_code; r_value <= n_value;
    end

    assign o_done  = r_done;
    assign o_code  = r_code;
    assign o_value = r_value;
endmodule
`default_nettype wire

@@ rtl/core/serial_command_line_parser.sv @@
// Serial command line parser: one byte a transaction; a newline parses the line.
// Plain bytes and carriage returns are accepted without holding the input off
// unless a result waits under a stall. A newline holds the input off while the
// scanner walks the line up to its length or its first zero byte, reading the
// line store one byte at a time (registered read). While the result waits under
// a stall, input is held off. Synchronous active-low reset clears length and control.
`default_nettype none
module serial_command_line_parser #(
    parameter int LINE_BYTES = 64,
    parameter int MAX_TOKENS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [3:0]  o_command_code,
    output logic      [31:0] o_command_value
);
    localparam int AW = $clog2(LINE_BYTES);

    logic [7:0]  r_mem [LINE_BYTES];
    logic [7:0]  r_rd_data;
    logic [AW:0] r_len;
    logic        r_busy, r_out_valid;
    logic [3:0]  r_code;
    logic [31:0] r_value;
    logic        accept, start, done;
    logic [AW-1:0] rd_addr;
    logic [3:0]  s_code;
    logic [31:0] s_value;

    assign o_stall = r_busy || (r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;
    assign start   = accept && (i_rx_byte == sclp_pkg::CH_LF);

    always_ff @(posedge i_clk) begin
        if (accept && i_rx_byte != sclp_pkg::CH_LF && i_rx_byte != sclp_pkg::CH_CR
            && r_len < (AW+1)'(LINE_BYTES - 1))
            r_mem[r_len[AW-1:0]] <= i_rx_byte;
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_busy <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (start) r_busy <= 1'b1;
            else if (done) r_busy <= 1'b0;
            if (done) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
            if (done) r_len <= '0;
            else if (accept && i_rx_byte != sclp_pkg::CH_LF && i_rx_byte != sclp_pkg::CH_CR
                     && r_len < (AW+1)'(LINE_BYTES - 1))
                r_len <= r_len + (AW+1)'(1);
        end
        if (done) begin
            r_code <= s_code;
            r_value <= s_value;
        end
    end

    sclp_scan #(.LINE_BYTES(LINE_BYTES), .MAX_TOKENS(MAX_TOKENS)) u_scan (
        .i_clk, .i_rst_n, .i_start(start), .i_len(r_len), .i_rd_data(r_rd_data),
        .o_rd_addr(rd_addr), .o_done(done), .o_code(s_code), .o_value(s_value)
    );

    assign o_valid = r_out_valid;
    assign o_command_code = r_code;
    assign o_command_value = r_value;
endmodule
`default_nettype wire
